// ===== hw/rtl/tvcu_pkg.sv =====
// Shared types and constants for the Toeplitz / vector command unit.
package tvcu_pkg;

    localparam int VEC_LEN_DEF    = 8;
    localparam int TBUF_DEPTH_DEF = 32;
    localparam int VBUF_DEPTH_DEF = 16;

    localparam int CMD_W     = 3;
    localparam int IDX_W     = 5;
    localparam int SIZE_W    = 4;
    localparam int WORD_W    = 32;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TADD  = 3'd0,
        CMD_VADD  = 3'd1,
        CMD_TVMUL = 3'd2,
        CMD_VSUB  = 3'd3,
        CMD_TLOAD = 3'd4,
        CMD_VLOAD = 3'd5
    } cmd_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// ===== hw/rtl/toeplitz_vector_command_unit.sv =====
// Top level: command sequencer, buffers, accumulators and result register.
//
//  channel | dir | tdata (low bit up)                               | tuser      | tlast
//  s_      | in  | center_a, center_b, store_addr, size, data, pad  | cmd        | -
//  m_      | out | addr, value, pad                                 | buffer_sel | last
//
// Each element passes ST_RD_A, ST_RD_B and ST_WR; Toeplitz add has 2n-1 elements, vector add/sub n.
// Multiply: n*n products through the single multiplier, a drain until the last row sum lands, then n write-backs.
// Every command that starts (a load, or any other with nonzero size) first wraps its start indices in ST_NORM.
// After reset a clearing pass zeroes every address of both buffers, with s_tready low.
// A stalled m_ channel holds the sequencer at its next write; s_tready is high only when idle.
module toeplitz_vector_command_unit import tvcu_pkg::*; #(
    parameter int VEC_LEN    = VEC_LEN_DEF,
    parameter int TBUF_DEPTH = TBUF_DEPTH_DEF,
    parameter int VBUF_DEPTH = VBUF_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // center_a, center_b, store_addr, size, data
    input  logic [CMD_W-1:0]     s_tuser,  // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // addr, value
    output logic                 m_tuser,  // buffer_sel
    output logic                 m_tlast
);

    localparam int TAW  = $clog2(TBUF_DEPTH);
    localparam int VAW  = $clog2(VBUF_DEPTH);
    localparam int DMAX = (TBUF_DEPTH > VBUF_DEPTH) ? TBUF_DEPTH : VBUF_DEPTH;
    localparam int PW   = $clog2(DMAX + 2 * VEC_LEN + 32) + 1;
    localparam int NW   = $clog2(VEC_LEN + 1);
    localparam int IW   = $clog2(VEC_LEN);
    localparam int CW   = $clog2(2 * VEC_LEN);
    localparam int CLW  = $clog2(DMAX);

    localparam logic signed [PW-1:0] P_ONE = PW'(1);
    localparam logic signed [PW-1:0] TD    = PW'(TBUF_DEPTH);
    localparam logic signed [PW-1:0] VD    = PW'(VBUF_DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NORM,
        ST_RD_A,
        ST_RD_B,
        ST_WR,
        ST_MAC,
        ST_DRAIN,
        ST_WB,
        ST_LOAD
    } state_t;

    function automatic logic signed [PW-1:0] step_ptr(input logic signed [PW-1:0] p,
                                                      input logic signed [PW-1:0] d,
                                                      input logic dec);
        logic signed [PW-1:0] r;
        if (dec) begin
            r = (p == '0) ? d - P_ONE : p - P_ONE;
        end else begin
            r = (p == d - P_ONE) ? '0 : p + P_ONE;
        end
        return r;
    endfunction

    function automatic logic signed [PW-1:0] norm_ptr(input logic signed [PW-1:0] p,
                                                      input logic signed [PW-1:0] d);
        logic signed [PW-1:0] r;
        if (p[PW-1]) begin
            r = p + d;
        end else if (p >= d) begin
            r = p - d;
        end else begin
            r = p;
        end
        return r;
    endfunction

    function automatic logic in_range(input logic signed [PW-1:0] p,
                                      input logic signed [PW-1:0] d);
        return !p[PW-1] && (p < d);
    endfunction

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 tsel_reg, tsel_next;
    logic                 dec_reg, dec_next;
    logic signed [PW-1:0] pa_reg, pa_next;
    logic signed [PW-1:0] pb_reg, pb_next;
    logic signed [PW-1:0] ps_reg, ps_next;
    logic signed [PW-1:0] trow_reg, trow_next;
    logic signed [PW-1:0] da_reg, da_next;
    logic signed [PW-1:0] db_reg, db_next;
    logic signed [PW-1:0] ds_reg, ds_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        lastc_reg, lastc_next;
    logic [IW-1:0]        nm1_reg, nm1_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [IW-1:0]        wrow_reg, wrow_next;
    word_t                x_reg, x_next;
    word_t                data_reg, data_next;
    logic [CLW-1:0]       clr_reg, clr_next;
    mac_ctl_t             mac_ctl_reg, mac_ctl_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_sel_reg, out_sel_next;
    logic [IDX_W-1:0]     out_addr_reg, out_addr_next;
    word_t                out_value_reg, out_value_next;
    logic                 out_last_reg, out_last_next;

    word_t accum_reg [VEC_LEN];

    cmd_t                 cmd_in;
    logic [IDX_W-1:0]     in_a, in_b, in_s;
    logic [SIZE_W-1:0]    in_size;
    word_t                in_data;
    logic [NW-1:0]        n_in;
    logic [IW-1:0]        nm1_in;
    logic signed [PW-1:0] a_s, b_s, s_s, nm1_s, off0;

    logic             out_free;
    logic             out_load;
    logic             t_we, v_we;
    logic [TAW-1:0]   t_waddr, t_raddr;
    logic [VAW-1:0]   v_waddr, v_raddr;
    word_t            wdata;
    word_t            t_rdata, v_rdata;
    alu_op_t          alu_op;
    word_t            alu_result;
    logic             alu_done;

    assign cmd_in  = cmd_t'(s_tuser);
    assign in_a    = s_tdata[4:0];
    assign in_b    = s_tdata[9:5];
    assign in_s    = s_tdata[14:10];
    assign in_size = s_tdata[18:15];
    assign in_data = s_tdata[50:19];
    assign n_in    = (int'(in_size) > VEC_LEN) ? NW'(VEC_LEN) : NW'(in_size);
    assign nm1_in  = IW'(n_in - NW'(1));
    assign a_s     = PW'(in_a);
    assign b_s     = PW'(in_b);
    assign s_s     = PW'(in_s);
    assign nm1_s   = PW'(n_in) - P_ONE;
    assign off0    = (in_a < in_b) ? -nm1_s : nm1_s;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign t_raddr = (state_reg == ST_RD_B || state_reg == ST_WR) ? pb_reg[TAW-1:0]
                                                                  : pa_reg[TAW-1:0];
    assign v_raddr = (state_reg == ST_RD_B || state_reg == ST_WR || state_reg == ST_MAC)
                     ? pb_reg[VAW-1:0] : pa_reg[VAW-1:0];
    assign alu_op  = (cmd_reg == CMD_VSUB) ? ALU_SUB : ALU_ADD;

    tvcu_ram #(.WIDTH(WORD_W), .DEPTH(TBUF_DEPTH)) u_tbuf (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    tvcu_ram #(.WIDTH(WORD_W), .DEPTH(VBUF_DEPTH)) u_vbuf (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    tvcu_alu u_alu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (alu_op),
        .opa      (x_reg),
        .opb      (tsel_reg ? t_rdata : v_rdata),
        .mac_ctl  (mac_ctl_reg),
        .mul_a    (t_rdata),
        .mul_b    (v_rdata),
        .result   (alu_result),
        .mac_done (alu_done)
    );

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        tsel_next      = tsel_reg;
        dec_next       = dec_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        ps_next        = ps_reg;
        trow_next      = trow_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        ds_next        = ds_reg;
        cnt_next       = cnt_reg;
        lastc_next     = lastc_reg;
        nm1_next       = nm1_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        wrow_next      = alu_done ? wrow_reg + IW'(1) : wrow_reg;
        x_next         = x_reg;
        data_next      = data_reg;
        clr_next       = clr_reg;
        mac_ctl_next   = '0;
        m_valid_next   = m_valid_reg && !m_tready;
        out_sel_next   = out_sel_reg;
        out_addr_next  = out_addr_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;
        t_we           = 1'b0;
        v_we           = 1'b0;
        t_waddr        = ps_reg[TAW-1:0];
        v_waddr        = ps_reg[VAW-1:0];
        wdata          = alu_result;

        unique case (state_reg)
            ST_CLEAR: begin
                t_we     = int'(clr_reg) < TBUF_DEPTH;
                v_we     = int'(clr_reg) < VBUF_DEPTH;
                t_waddr  = TAW'(clr_reg);
                v_waddr  = VAW'(clr_reg);
                wdata    = '0;
                clr_next = clr_reg + CLW'(1);
                if (int'(clr_reg) == DMAX - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = cmd_in;
                    nm1_next  = nm1_in;
                    data_next = in_data;
                    cnt_next  = '0;
                    i_next    = '0;
                    k_next    = '0;
                    wrow_next = '0;
                    dec_next  = 1'b0;
                    unique case (cmd_in)
                        CMD_TADD: begin
                            if (n_in != '0) begin
                                tsel_next  = 1'b1;
                                dec_next   = !(in_a < in_b);
                                pa_next    = a_s + off0;
                                pb_next    = b_s + off0;
                                ps_next    = s_s + off0;
                                da_next    = TD;
                                db_next    = TD;
                                ds_next    = TD;
                                lastc_next = CW'({nm1_in, 1'b0});
                                state_next = ST_NORM;
                            end
                        end
                        CMD_VADD, CMD_VSUB: begin
                            if (n_in != '0) begin
                                tsel_next  = 1'b0;
                                pa_next    = a_s;
                                pb_next    = b_s;
                                ps_next    = s_s;
                                da_next    = VD;
                                db_next    = VD;
                                ds_next    = VD;
                                lastc_next = CW'(nm1_in);
                                state_next = ST_NORM;
                            end
                        end
                        CMD_TVMUL: begin
                            if (n_in != '0) begin
                                pa_next    = a_s - nm1_s;
                                pb_next    = b_s;
                                ps_next    = b_s;
                                da_next    = TD;
                                db_next    = VD;
                                ds_next    = VD;
                                state_next = ST_NORM;
                            end
                        end
                        CMD_TLOAD, CMD_VLOAD: begin
                            tsel_next  = (cmd_in == CMD_TLOAD);
                            pa_next    = '0;
                            pb_next    = '0;
                            ps_next    = s_s;
                            da_next    = TD;
                            db_next    = TD;
                            ds_next    = (cmd_in == CMD_TLOAD) ? TD : VD;
                            state_next = ST_NORM;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NORM: begin
                pa_next = norm_ptr(pa_reg, da_reg);
                pb_next = norm_ptr(pb_reg, db_reg);
                ps_next = norm_ptr(ps_reg, ds_reg);
                if (in_range(pa_reg, da_reg) && in_range(pb_reg, db_reg)
                    && in_range(ps_reg, ds_reg)) begin
                    unique case (cmd_reg)
                        CMD_TADD, CMD_VADD, CMD_VSUB: state_next = ST_RD_A;
                        CMD_TVMUL: begin
                            trow_next  = pa_reg;
                            state_next = ST_MAC;
                        end
                        CMD_TLOAD, CMD_VLOAD: state_next = ST_LOAD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_A: begin
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                x_next     = tsel_reg ? t_rdata : v_rdata;
                state_next = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    t_we           = tsel_reg;
                    v_we           = !tsel_reg;
                    out_load       = 1'b1;
                    m_valid_next   = 1'b1;
                    out_sel_next   = !tsel_reg;
                    out_addr_next  = IDX_W'(ps_reg);
                    out_value_next = alu_result;
                    out_last_next  = (cnt_reg == lastc_reg);
                    pa_next        = step_ptr(pa_reg, da_reg, dec_reg);
                    pb_next        = step_ptr(pb_reg, db_reg, dec_reg);
                    ps_next        = step_ptr(ps_reg, ds_reg, dec_reg);
                    cnt_next       = cnt_reg + CW'(1);
                    state_next     = (cnt_reg == lastc_reg) ? ST_IDLE : ST_RD_A;
                end
            end
            ST_MAC: begin
                mac_ctl_next.valid = 1'b1;
                mac_ctl_next.first = (k_reg == '0);
                mac_ctl_next.last  = (k_reg == nm1_reg);
                if (k_reg == nm1_reg) begin
                    k_next    = '0;
                    i_next    = i_reg + IW'(1);
                    trow_next = step_ptr(trow_reg, da_reg, 1'b0);
                    pa_next   = step_ptr(trow_reg, da_reg, 1'b0);
                    pb_next   = ps_reg;
                    if (i_reg == nm1_reg) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    k_next  = k_reg + IW'(1);
                    pa_next = step_ptr(pa_reg, da_reg, 1'b0);
                    pb_next = step_ptr(pb_reg, db_reg, 1'b0);
                end
            end
            ST_DRAIN: begin
                if (alu_done && wrow_reg == nm1_reg) begin
                    i_next     = '0;
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                wdata = accum_reg[i_reg];
                if (out_free) begin
                    v_we           = 1'b1;
                    out_load       = 1'b1;
                    m_valid_next   = 1'b1;
                    out_sel_next   = 1'b1;
                    out_addr_next  = IDX_W'(ps_reg);
                    out_value_next = accum_reg[i_reg];
                    out_last_next  = (i_reg == nm1_reg);
                    ps_next        = step_ptr(ps_reg, ds_reg, 1'b0);
                    i_next         = i_reg + IW'(1);
                    if (i_reg == nm1_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LOAD: begin
                wdata = data_reg;
                if (out_free) begin
                    t_we           = tsel_reg;
                    v_we           = !tsel_reg;
                    out_load       = 1'b1;
                    m_valid_next   = 1'b1;
                    out_sel_next   = !tsel_reg;
                    out_addr_next  = IDX_W'(ps_reg);
                    out_value_next = data_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            mac_ctl_reg <= '0;
            m_valid_reg <= 1'b0;
            wrow_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            mac_ctl_reg <= mac_ctl_next;
            m_valid_reg <= m_valid_next;
            wrow_reg    <= wrow_next;
        end
        cmd_reg       <= cmd_next;
        tsel_reg      <= tsel_next;
        dec_reg       <= dec_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        ps_reg        <= ps_next;
        trow_reg      <= trow_next;
        da_reg        <= da_next;
        db_reg        <= db_next;
        ds_reg        <= ds_next;
        cnt_reg       <= cnt_next;
        lastc_reg     <= lastc_next;
        nm1_reg       <= nm1_next;
        i_reg         <= i_next;
        k_reg         <= k_next;
        x_reg         <= x_next;
        data_reg      <= data_next;
        out_sel_reg   <= out_sel_next;
        out_addr_reg  <= out_addr_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (alu_done) begin
            accum_reg[wrow_reg] <= alu_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W - WORD_W){1'b0}}, out_value_reg, out_addr_reg};
    assign m_tuser  = out_sel_reg;
    assign m_tlast  = out_last_reg;

    // read pointers stay wrapped while buffers are being addressed
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_A || state_reg == ST_MAC)
        |-> (!pa_reg[PW-1] && pa_reg < da_reg))
        else $error("source pointer out of buffer range");

    a_mac_done_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == ST_MAC || state_reg == ST_DRAIN))
        else $error("dot product completed outside multiply");

    a_last_ends_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_last_next) |=> (state_reg == ST_IDLE))
        else $error("final transaction did not end the command");

    a_no_emit_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC || state_reg == ST_DRAIN) |-> !out_load)
        else $error("result emitted before dot products finished");

endmodule

// ===== hw/rtl/tvcu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tvcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tvcu_alu.sv =====
// Shared arithmetic unit: one adder for add/subtract and accumulate, one registered multiplier.
module tvcu_alu import tvcu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_op_t  op,
    input  word_t    opa,
    input  word_t    opb,
    input  mac_ctl_t mac_ctl,
    input  word_t    mul_a,
    input  word_t    mul_b,
    output word_t    result,
    output logic     mac_done
);

    word_t    prod_reg;
    word_t    acc_reg;
    mac_ctl_t ctl_reg;
    word_t    in0;
    word_t    in1;
    logic     sub;

    always_comb begin
        if (ctl_reg.valid) begin
            in0 = ctl_reg.first ? '0 : acc_reg;
            in1 = prod_reg;
            sub = 1'b0;
        end else begin
            in0 = opa;
            in1 = opb;
            sub = (op == ALU_SUB);
        end
        result = in0 + (in1 ^ {WORD_W{sub}}) + word_t'(sub);
    end

    assign mac_done = ctl_reg.valid && ctl_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= mac_ctl;
        end
        prod_reg <= mul_a * mul_b;
        if (ctl_reg.valid) begin
            acc_reg <= result;
        end
    end

endmodule
